### design/tmma_pkg.sv
// Shared types and constants for the tiled matrix multiply-accumulate block.
// Holds the function codes, the sequencer states and the fixed datapath widths.
// No dependencies.
package tmma_pkg;

    // Widths fixed by the item fields and the configuration registers.
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 6;
    localparam int AB_W    = 16;
    localparam int C_W     = 48;
    localparam int PROD_W  = 2 * AB_W;
    // Loop counters hold tile origins plus one tile, both below 128.
    localparam int CNT_W   = 8;
    // A tile sum has at most 127 products of magnitude up to 2^30.
    localparam int ACC_W   = 38;
    localparam int SUM_W   = C_W + 2;

    // Function codes carried by the func field of an input beat.
    typedef enum logic [2:0] {
        FUNC_WR_A = 3'd0,
        FUNC_WR_B = 3'd1,
        FUNC_WR_C = 3'd2,
        FUNC_MAC  = 3'd3,
        FUNC_RD_C = 3'd4
    } func_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_CWR,
        ST_RESP
    } state_t;

    // Configuration register indexes.
    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic REG_TILE_SIZE   = 1'b1;

    localparam logic [CFG_W-1:0] MATRIX_SIZE_RESET = 7'd64;
    localparam logic [CFG_W-1:0] TILE_SIZE_RESET   = 7'd64;

endpackage

### design/tiled_matrix_multiply_accumulate.sv
// Tiled matrix multiply-accumulate, C += A*B, with A, B and C in on-chip memories.
// Element writes go straight to the memories; a C read passes through the C read
// register and the output register, where result back-pressure can hold it. A
// multiply steps, for each tile and C element, through ST_MAC along the inner tile,
// then ST_DRAIN1, ST_DRAIN2 and ST_CWR, paced by the one-read-per-cycle A and B ports.
// After reset the size registers hold 64; there is no pass that clears the memories.
module tiled_matrix_multiply_accumulate #(
    parameter int MAX_DIM = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Input items.
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic [2:0]                       func,
    input  logic [tmma_pkg::IDX_W-1:0]       row,
    input  logic [tmma_pkg::IDX_W-1:0]       col,
    input  logic signed [tmma_pkg::C_W-1:0]  value,
    // Result items.
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic [tmma_pkg::IDX_W-1:0]       row_res,
    output logic [tmma_pkg::IDX_W-1:0]       col_res,
    output logic signed [tmma_pkg::C_W-1:0]  value_res
);

    localparam int CNT_W  = tmma_pkg::CNT_W;
    localparam int AB_W   = tmma_pkg::AB_W;
    localparam int C_W    = tmma_pkg::C_W;
    localparam int ACC_W  = tmma_pkg::ACC_W;
    localparam int SUM_W  = tmma_pkg::SUM_W;
    localparam int PROD_W = tmma_pkg::PROD_W;
    localparam int CFG_W  = tmma_pkg::CFG_W;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic signed [C_W-1:0] SAT_MAX = {1'b0, {(C_W - 1){1'b1}}};
    localparam logic signed [C_W-1:0] SAT_MIN = {1'b1, {(C_W - 1){1'b0}}};

    // Row-major cell address.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] r,
                                                    input logic [CNT_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    tmma_pkg::state_t state_reg, state_next;

    logic [CFG_W-1:0] cfg_size_reg, cfg_tile_reg;

    logic [CNT_W-1:0] n_reg, n_next, t_reg, t_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CNT_W-1:0] ii_reg, ii_next, jj_reg, jj_next, kk_reg, kk_next;

    logic                      rd_vld_reg, prod_vld_reg;
    logic signed [AB_W-1:0]    a_q_reg, b_q_reg;
    logic signed [C_W-1:0]     c_q_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   sum;
    logic signed [C_W-1:0]     sat_sum;

    logic                      rd_inside_reg;
    logic [tmma_pkg::IDX_W-1:0] rd_row_reg, rd_col_reg;

    logic                      out_valid_reg;
    logic [tmma_pkg::IDX_W-1:0] out_row_reg, out_col_reg;
    logic signed [C_W-1:0]     out_value_reg;
    logic                      out_load;

    logic                      item_accept;
    logic                      in_inside;
    tmma_pkg::func_t           func_code;
    logic [ADDR_W-1:0]         in_addr;

    logic                      a_we, b_we, c_we, c_re;
    logic [ADDR_W-1:0]         c_addr;
    logic signed [C_W-1:0]     c_wdata;

    logic [CNT_W-1:0]          n_cfg, t_cfg;

    // Configuration registers, written on the access phase of an APB write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_size_reg <= tmma_pkg::MATRIX_SIZE_RESET;
            cfg_tile_reg <= tmma_pkg::TILE_SIZE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == tmma_pkg::REG_MATRIX_SIZE)
                cfg_size_reg <= pwdata[CFG_W-1:0];
            else
                cfg_tile_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tmma_pkg::REG_TILE_SIZE) ? 32'(cfg_tile_reg)
                                                          : 32'(cfg_size_reg);

    // Effective sizes: matrix size capped at the store edge, tile size at least one.
    always_comb
    begin
        if (int'(cfg_size_reg) > MAX_DIM)
            n_cfg = CNT_W'(MAX_DIM);
        else
            n_cfg = CNT_W'(cfg_size_reg);
        t_cfg = (cfg_tile_reg == '0) ? CNT_W'(1) : CNT_W'(cfg_tile_reg);
    end

    // Input beat decode.
    assign item_ready  = (state_reg == tmma_pkg::ST_IDLE);
    assign item_accept = item_valid && item_ready;
    assign func_code   = tmma_pkg::func_t'(func);
    assign in_inside   = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign in_addr     = cell_addr(CNT_W'(row), CNT_W'(col));

    // Saturating update of the C element with the tile partial sum.
    always_comb
    begin
        sum = SUM_W'(c_q_reg) + SUM_W'(acc_reg);
        if (sum[SUM_W-1:C_W-1] == '0 || sum[SUM_W-1:C_W-1] == '1)
            sat_sum = sum[C_W-1:0];
        else if (sum[SUM_W-1])
            sat_sum = SAT_MIN;
        else
            sat_sum = SAT_MAX;
    end

    // Sequencer: next state, loop counters and memory controls.
    always_comb
    begin
        logic [CNT_W-1:0] k_end, i_end, j_end;
        k_end = (k_reg + t_reg < n_reg) ? k_reg + t_reg : n_reg;
        i_end = (i_reg + t_reg < n_reg) ? i_reg + t_reg : n_reg;
        j_end = (j_reg + t_reg < n_reg) ? j_reg + t_reg : n_reg;

        state_next = state_reg;
        n_next  = n_reg;
        t_next  = t_reg;
        i_next  = i_reg;
        j_next  = j_reg;
        k_next  = k_reg;
        ii_next = ii_reg;
        jj_next = jj_reg;
        kk_next = kk_reg;
        a_we    = 1'b0;
        b_we    = 1'b0;
        c_we    = 1'b0;
        c_re    = 1'b0;
        c_addr  = cell_addr(ii_reg, jj_reg);
        c_wdata = sat_sum;
        out_load = 1'b0;

        case (state_reg)
            tmma_pkg::ST_IDLE:
            begin
                c_addr  = in_addr;
                c_wdata = value;
                if (item_accept)
                begin
                    case (func_code)
                        tmma_pkg::FUNC_WR_A: a_we = in_inside;
                        tmma_pkg::FUNC_WR_B: b_we = in_inside;
                        tmma_pkg::FUNC_WR_C: c_we = in_inside;
                        tmma_pkg::FUNC_MAC:
                        begin
                            n_next  = n_cfg;
                            t_next  = t_cfg;
                            i_next  = '0;
                            j_next  = '0;
                            k_next  = '0;
                            ii_next = '0;
                            jj_next = '0;
                            kk_next = '0;
                            if (n_cfg != '0)
                                state_next = tmma_pkg::ST_MAC;
                        end
                        tmma_pkg::FUNC_RD_C:
                        begin
                            c_re       = in_inside;
                            state_next = tmma_pkg::ST_RESP;
                        end
                        default: ;
                    endcase
                end
            end
            tmma_pkg::ST_MAC:
            begin
                // One A and one B read issued per cycle along the inner index.
                kk_next = kk_reg + 1'b1;
                if (kk_reg + 1'b1 >= k_end)
                    state_next = tmma_pkg::ST_DRAIN1;
            end
            tmma_pkg::ST_DRAIN1:
            begin
                c_re       = 1'b1;
                state_next = tmma_pkg::ST_DRAIN2;
            end
            tmma_pkg::ST_DRAIN2:
            begin
                state_next = tmma_pkg::ST_CWR;
            end
            tmma_pkg::ST_CWR:
            begin
                c_we       = 1'b1;
                state_next = tmma_pkg::ST_MAC;
                if (jj_reg + 1'b1 < j_end)
                begin
                    jj_next = jj_reg + 1'b1;
                end
                else if (ii_reg + 1'b1 < i_end)
                begin
                    ii_next = ii_reg + 1'b1;
                    jj_next = j_reg;
                end
                else
                begin
                    // Tile finished: step the inner tile, then columns, then rows.
                    if (k_reg + t_reg < n_reg)
                        k_next = k_reg + t_reg;
                    else
                    begin
                        k_next = '0;
                        if (j_reg + t_reg < n_reg)
                            j_next = j_reg + t_reg;
                        else
                        begin
                            j_next = '0;
                            if (i_reg + t_reg < n_reg)
                                i_next = i_reg + t_reg;
                            else
                            begin
                                i_next     = '0;
                                state_next = tmma_pkg::ST_IDLE;
                            end
                        end
                    end
                    ii_next = i_next;
                    jj_next = j_next;
                end
                kk_next = k_next;
            end
            tmma_pkg::ST_RESP:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_load   = 1'b1;
                    state_next = tmma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmma_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmma_pkg::ST_IDLE;
            n_reg         <= '0;
            t_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ii_reg        <= '0;
            jj_reg        <= '0;
            kk_reg        <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            t_reg        <= t_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            ii_reg       <= ii_next;
            jj_reg       <= jj_next;
            kk_reg       <= kk_next;
            rd_vld_reg   <= (state_reg == tmma_pkg::ST_MAC);
            prod_vld_reg <= rd_vld_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Multiply and accumulate pipeline; the sum restarts after each C update.
    always_ff @(posedge clk)
    begin
        prod_reg <= a_q_reg * b_q_reg;
        if (state_reg == tmma_pkg::ST_IDLE || state_reg == tmma_pkg::ST_CWR)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Read request details and the output register.
    always_ff @(posedge clk)
    begin
        if (state_reg == tmma_pkg::ST_IDLE)
        begin
            rd_inside_reg <= in_inside;
            rd_row_reg    <= row;
            rd_col_reg    <= col;
        end
        if (out_load)
        begin
            out_row_reg   <= rd_row_reg;
            out_col_reg   <= rd_col_reg;
            out_value_reg <= rd_inside_reg ? c_q_reg : '0;
        end
    end

    assign res_valid = out_valid_reg;
    assign row_res   = out_row_reg;
    assign col_res   = out_col_reg;
    assign value_res = out_value_reg;

    // Matrix A store, read along a row of the current tile.
    logic signed [AB_W-1:0] mem_a [DEPTH];
    always_ff @(posedge clk)
    begin
        if (a_we)
            mem_a[in_addr] <= value[AB_W-1:0];
        a_q_reg <= mem_a[cell_addr(ii_reg, kk_reg)];
    end

    // Matrix B store, read down a column of the current tile.
    logic signed [AB_W-1:0] mem_b [DEPTH];
    always_ff @(posedge clk)
    begin
        if (b_we)
            mem_b[in_addr] <= value[AB_W-1:0];
        b_q_reg <= mem_b[cell_addr(kk_reg, jj_reg)];
    end

    // Matrix C store, read-modify-write per element and tile.
    logic signed [C_W-1:0] mem_c [DEPTH];
    always_ff @(posedge clk)
    begin
        if (c_we)
            mem_c[c_addr] <= c_wdata;
        if (c_re)
            c_q_reg <= mem_c[c_addr];
    end

endmodule

### bench/tb_top.sv
// Self-checking bench for the tiled matrix multiply-accumulate block.
// Drives element, multiply and read beats and checks every C read against a shadow model or a typed expectation.
// Depends on tmma_pkg and tiled_matrix_multiply_accumulate.
`timescale 1ns / 100ps

module tb_top;

    localparam int     DIM          = 64;
    localparam int     HALF_PERIOD  = 6;
    localparam longint LIMIT_NS     = 64'd60_000_000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     END_WAIT_LIMIT = 1_000_000;
    localparam int     ITEMS_PER_PHASE = 550;
    localparam int     PRINT_CAP    = 100;

    // Function codes the block does not decode; such beats are dropped.
    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    localparam longint     SAT_HI = (64'sd1 <<< 47) - 64'sd1;
    localparam longint     SAT_LO = -SAT_HI - 64'sd1;
    localparam logic [47:0] C_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] C_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic [5:0]  r;
        logic [5:0]  c;
        logic [47:0] v;
    } c_read_t;

    typedef struct {
        logic [2:0]  fn;
        logic [5:0]  r;
        logic [5:0]  c;
        logic [47:0] v;
        bit          typed;
        logic [47:0] want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              item_valid = 1'b0;
    logic              item_ready;
    logic [2:0]        func = '0;
    logic [5:0]        row = '0;
    logic [5:0]        col = '0;
    logic signed [47:0] value = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    logic [5:0]        row_res;
    logic [5:0]        col_res;
    logic signed [47:0] value_res;

    // Typed expectation that travels with the beat on the item channel.
    logic              drv_typed = 1'b0;
    logic [47:0]       drv_want = '0;

    // Shadow copy of the block's memories and size registers.
    logic signed [15:0] shadow_a [DIM*DIM];
    logic signed [15:0] shadow_b [DIM*DIM];
    logic signed [47:0] shadow_c [DIM*DIM];
    int                cfg_matrix_size = 64;
    int                cfg_tile_size = 64;

    // Elements written since reset; multiplies and reads only touch written ones.
    bit                written_a [DIM*DIM];
    bit                written_b [DIM*DIM];
    bit                written_c [DIM*DIM];

    c_read_t           pending_c_reads [$];
    stim_row_t         directed [$];

    int                error_count = 0;
    int                random_items = 0;
    int                send_idle = 0;
    int                recv_idle = 0;

    tiled_matrix_multiply_accumulate #(
        .MAX_DIM (DIM)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .func       (func),
        .row        (row),
        .col        (col),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .row_res    (row_res),
        .col_res    (col_res),
        .value_res  (value_res)
    );

    // Free-running clock.
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < PRINT_CAP)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int imin(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint sat48(longint s);
        if (s > SAT_HI)
            return SAT_HI;
        if (s < SAT_LO)
            return SAT_LO;
        return s;
    endfunction

    // C += A*B over the leading corner, one saturating add per tile.
    task automatic shadow_multiply_accumulate();
        int     n;
        int     t;
        int     cidx;
        longint acc;
        n = imin(cfg_matrix_size, DIM);
        t = (cfg_tile_size == 0) ? 1 : cfg_tile_size;
        for (int i0 = 0; i0 < n; i0 += t)
            for (int j0 = 0; j0 < n; j0 += t)
                for (int k0 = 0; k0 < n; k0 += t)
                    for (int ii = i0; ii < imin(i0 + t, n); ii++)
                        for (int jj = j0; jj < imin(j0 + t, n); jj++)
                        begin
                            acc = 0;
                            cidx = ii * DIM + jj;
                            for (int kk = k0; kk < imin(k0 + t, n); kk++)
                                acc += longint'(shadow_a[ii * DIM + kk])
                                     * longint'(shadow_b[kk * DIM + jj]);
                            shadow_c[cidx] = 48'(sat48(longint'(shadow_c[cidx]) + acc));
                        end
    endtask

    // Applies one accepted beat to the shadow state; reads yield a C value.
    task automatic shadow_apply_beat(input logic [2:0] fn, input logic [5:0] r,
                                     input logic [5:0] cl, input logic [47:0] v,
                                     output bit gives, output logic [47:0] val);
        int idx;
        idx = int'(r) * DIM + int'(cl);
        gives = 1'b0;
        val = '0;
        case (fn)
            tmma_pkg::FUNC_WR_A:
            begin
                shadow_a[idx] = v[15:0];
                written_a[idx] = 1'b1;
            end
            tmma_pkg::FUNC_WR_B:
            begin
                shadow_b[idx] = v[15:0];
                written_b[idx] = 1'b1;
            end
            tmma_pkg::FUNC_WR_C:
            begin
                shadow_c[idx] = v;
                written_c[idx] = 1'b1;
            end
            tmma_pkg::FUNC_MAC:  shadow_multiply_accumulate();
            tmma_pkg::FUNC_RD_C:
            begin
                gives = 1'b1;
                val = shadow_c[idx];
            end
            default: ;
        endcase
    endtask

    // Watch both channels at the rising edge: check result beats, predict item beats.
    always @(posedge clk)
    begin
        c_read_t     due;
        bit          gives;
        logic [47:0] val;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (pending_c_reads.size() == 0)
                    report_mismatch("result beat with no read due", value_res, '0);
                else
                begin
                    due = pending_c_reads.pop_front();
                    if (row_res !== due.r)
                        report_mismatch("row_res", row_res, due.r);
                    if (col_res !== due.c)
                        report_mismatch("col_res", col_res, due.c);
                    if (value_res !== due.v)
                        report_mismatch("value_res", value_res, due.v);
                end
            end
            if (item_valid && item_ready)
            begin
                shadow_apply_beat(func, row, col, value, gives, val);
                if (gives)
                begin
                    due.r = row;
                    due.c = col;
                    due.v = drv_typed ? drv_want : val;
                    pending_c_reads.push_back(due);
                end
            end
        end
    end

    // Result back-pressure at the current idle rate.
    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Register read with the value compared; leaves the bus idle afterwards.
    task automatic cfg_readback(logic idx, int want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(want))
            report_mismatch(idx == tmma_pkg::REG_MATRIX_SIZE ? "matrix_size readback"
                                                             : "tile_size readback",
                            prdata, 32'(want));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Register write followed by a read-back. Called at a falling edge.
    task automatic cfg_write(logic idx, int val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == tmma_pkg::REG_MATRIX_SIZE)
            cfg_matrix_size = val & 127;
        else
            cfg_tile_size = val & 127;
        @(negedge clk);
        cfg_readback(idx, val & 127);
    endtask

    // Presents one beat and holds it until accepted. Starts and ends at a falling edge.
    task automatic send_item(logic [2:0] fn, logic [5:0] r, logic [5:0] cl,
                             logic [47:0] v, bit typed, logic [47:0] want);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        func <= fn;
        row <= r;
        col <= cl;
        value <= v;
        drv_typed <= typed;
        drv_want <= want;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every read is answered and the block has gone quiet.
    task automatic drain_and_settle();
        while (pending_c_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic stim_row_t mk(logic [2:0] fn, logic [5:0] r, logic [5:0] cl,
                                     logic [47:0] v, bit typed, logic [47:0] want);
        stim_row_t s;
        s.fn = fn;
        s.r = r;
        s.c = cl;
        s.v = v;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // A/B element: random low 16 bits with junk above them, extremes now and then.
    function automatic logic [47:0] ab_value();
        logic [47:0] v;
        int          pick;
        v = rand48();
        pick = $urandom_range(9);
        if (pick == 0)
            v[15:0] = 16'h7FFF;
        else if (pick == 1)
            v[15:0] = 16'h8000;
        return v;
    endfunction

    // C element: half moderate, some near either saturation bound, the rest random.
    function automatic logic [47:0] c_value();
        logic [31:0] w;
        int          pick;
        w = $urandom;
        pick = $urandom_range(99);
        if (pick < 50)
            return {{16{w[31]}}, w};
        if (pick < 65)
            return 48'(SAT_HI - longint'(w[19:0]));
        if (pick < 80)
            return 48'(SAT_LO + longint'(w[19:0]));
        return rand48();
    endfunction

    function automatic logic [5:0] pick_index(int span);
        if ($urandom_range(99) < 85)
            return 6'($urandom_range(span - 1));
        return 6'($urandom_range(63));
    endfunction

    // Finds the first element of the leading n-by-n corner that is not yet written.
    function automatic bit find_gap(input int n, output logic [2:0] fn,
                                    output logic [5:0] r, output logic [5:0] cl);
        fn = tmma_pkg::FUNC_WR_A;
        r = '0;
        cl = '0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                r = 6'(i);
                cl = 6'(j);
                if (!written_a[i * DIM + j])
                begin
                    fn = tmma_pkg::FUNC_WR_A;
                    return 1'b1;
                end
                if (!written_b[i * DIM + j])
                begin
                    fn = tmma_pkg::FUNC_WR_B;
                    return 1'b1;
                end
                if (!written_c[i * DIM + j])
                begin
                    fn = tmma_pkg::FUNC_WR_C;
                    return 1'b1;
                end
            end
        return 1'b0;
    endfunction

    // One configuration followed by a burst of loads, multiplies and reads.
    task automatic run_round();
        int          n_cfg;
        int          t_cfg;
        int          span;
        int          len;
        int          pick;
        bit          mac_ok;
        bit          gap;
        logic [2:0]  fn;
        logic [2:0]  gap_fn;
        logic [5:0]  r;
        logic [5:0]  cl;
        logic [47:0] v;
        pick = $urandom_range(99);
        if (pick < 5)
            n_cfg = 0;
        else if (pick < 10)
            n_cfg = $urandom_range(127, 64);
        else if (pick < 85)
            n_cfg = $urandom_range(6, 1);
        else
            n_cfg = $urandom_range(12, 7);
        pick = $urandom_range(99);
        if (pick < 10)
            t_cfg = 0;
        else if (pick < 20)
            t_cfg = 127;
        else if (pick < 30)
            t_cfg = n_cfg;
        else
            t_cfg = $urandom_range(n_cfg + 2, 1);
        // Full-size multiplies are far too slow for a random round.
        mac_ok = (n_cfg <= 12);
        span = (n_cfg == 0) ? 4 : (mac_ok ? n_cfg : DIM);
        drain_and_settle();
        cfg_write(tmma_pkg::REG_MATRIX_SIZE, n_cfg);
        cfg_write(tmma_pkg::REG_TILE_SIZE, t_cfg);
        len = $urandom_range(70, 40);
        for (int k = 0; k < len; k++)
        begin
            pick = (k == len - 1) ? 99 : $urandom_range(99);
            v = rand48();
            if (pick < 16)
            begin
                fn = tmma_pkg::FUNC_WR_A;
                v = ab_value();
            end
            else if (pick < 32)
            begin
                fn = tmma_pkg::FUNC_WR_B;
                v = ab_value();
            end
            else if (pick < 42)
            begin
                fn = tmma_pkg::FUNC_WR_C;
                v = c_value();
            end
            else if (pick < 48 && mac_ok)
                fn = tmma_pkg::FUNC_MAC;
            else if (pick >= 48 && pick < 52)
                fn = 3'($urandom_range(FUNC_RSVD7, FUNC_RSVD5));
            else
                fn = tmma_pkg::FUNC_RD_C;
            r = pick_index(span);
            cl = pick_index(span);
            // A multiply waits until its corner is loaded; a read only sees a written C.
            if (fn == tmma_pkg::FUNC_MAC)
            begin
                gap = find_gap(imin(cfg_matrix_size, DIM), gap_fn, r, cl);
                if (gap)
                begin
                    fn = gap_fn;
                    v = (gap_fn == tmma_pkg::FUNC_WR_C) ? c_value() : ab_value();
                end
            end
            else if (fn == tmma_pkg::FUNC_RD_C && !written_c[int'(r) * DIM + int'(cl)])
            begin
                fn = tmma_pkg::FUNC_WR_C;
                v = c_value();
            end
            send_item(fn, r, cl, v, 1'b0, '0);
            if (fn <= tmma_pkg::FUNC_RD_C)
                random_items++;
        end
        item_valid <= 1'b0;
    endtask

    // Main sequence.
    initial
    begin
        int wait_cnt;
        send_idle = 26;
        recv_idle = 51;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers come out of reset at full size.
        cfg_readback(tmma_pkg::REG_MATRIX_SIZE, tmma_pkg::MATRIX_SIZE_RESET);
        cfg_readback(tmma_pkg::REG_TILE_SIZE, tmma_pkg::TILE_SIZE_RESET);

        // Directed rows on a one-element corner with a zero tile size.
        cfg_write(tmma_pkg::REG_MATRIX_SIZE, 1);
        cfg_write(tmma_pkg::REG_TILE_SIZE, 0);
        directed.push_back(mk(tmma_pkg::FUNC_WR_C, 6'd0, 6'd0, C_MAX, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_RD_C, 6'd0, 6'd0, '0, 1'b1, C_MAX));
        directed.push_back(mk(tmma_pkg::FUNC_WR_C, 6'd63, 6'd63, C_MIN, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_RD_C, 6'd63, 6'd63, '1, 1'b1, C_MIN));
        directed.push_back(mk(tmma_pkg::FUNC_WR_A, 6'd0, 6'd0, 48'hFFFF_FFFF_7FFF, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_WR_B, 6'd0, 6'd0, 48'h0000_0000_7FFF, 1'b0, '0));
        // A positive product pushes a full-scale C into saturation.
        directed.push_back(mk(tmma_pkg::FUNC_MAC, 6'd0, 6'd0, '0, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_RD_C, 6'd0, 6'd0, '0, 1'b1, C_MAX));
        directed.push_back(mk(tmma_pkg::FUNC_WR_C, 6'd0, 6'd0, C_MIN, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_WR_A, 6'd0, 6'd0, 48'h5555_5555_8000, 1'b0, '0));
        // A negative product on the most negative C stays clamped.
        directed.push_back(mk(tmma_pkg::FUNC_MAC, 6'd0, 6'd0, '0, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_RD_C, 6'd0, 6'd0, '0, 1'b1, C_MIN));
        // Spare function codes are dropped without a result.
        directed.push_back(mk(FUNC_RSVD5, 6'd0, 6'd0, '0, 1'b0, '0));
        directed.push_back(mk(FUNC_RSVD6, 6'd63, 6'd0, C_MAX, 1'b0, '0));
        directed.push_back(mk(FUNC_RSVD7, 6'd0, 6'd63, '1, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_RD_C, 6'd0, 6'd0, '0, 1'b1, C_MIN));
        directed.push_back(mk(tmma_pkg::FUNC_WR_C, 6'd0, 6'd0, '0, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_WR_B, 6'd0, 6'd0, 48'hAAAA_AAAA_8000, 1'b0, '0));
        // Most negative times most negative is the largest product.
        directed.push_back(mk(tmma_pkg::FUNC_MAC, 6'd0, 6'd0, '0, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_RD_C, 6'd0, 6'd0, '0, 1'b0, '0));
        directed.push_back(mk(tmma_pkg::FUNC_RD_C, 6'd63, 6'd63, '0, 1'b1, C_MIN));
        foreach (directed[i])
            send_item(directed[i].fn, directed[i].r, directed[i].c, directed[i].v,
                      directed[i].typed, directed[i].want);
        item_valid <= 1'b0;
        drain_and_settle();

        // Random rounds under three idling patterns.
        for (int p = 0; p < 3; p++)
        begin
            int phase_start;
            if (p == 1)
            begin
                send_idle = 51;
                recv_idle = 26;
            end
            else if (p == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            phase_start = random_items;
            while (random_items - phase_start < ITEMS_PER_PHASE)
                run_round();
        end

        // Let outstanding reads come back, then a short settle.
        wait_cnt = 0;
        while (pending_c_reads.size() != 0 && wait_cnt < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_c_reads.size() != 0)
            report_mismatch("reads never answered", pending_c_reads.size(), '0);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

### tiled_matrix_multiply_accumulate.f
design/tmma_pkg.sv
design/tiled_matrix_multiply_accumulate.sv
bench/tb_top.sv
